FILE: rtl/mpfl_pkg.sv
// ----------------------------------------------------------------------------
// mpfl_pkg
// Shared sizes, codes and types of the multi-pool free list allocator.
// ----------------------------------------------------------------------------
package mpfl_pkg;

	// pool geometry
	localparam int NUM_POOLS  = 7;
	localparam int POOL_DEPTH = 64;

	// fixed field widths of the request and result channels
	localparam int OP_W     = 2;
	localparam int POOL_W   = 3;
	localparam int ENTRY_W  = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// derived internal widths
	localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int EW    = $clog2(POOL_DEPTH);
	localparam int CW    = $clog2(POOL_DEPTH + 1);
	localparam int SLOTS = NUM_POOLS * POOL_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int TW    = $clog2(SLOTS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_COMMIT  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_SUCCESS   = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_ALLOC = 2'd2,
		STAT_PENDING   = 2'd3
	} status_t;

	typedef struct packed {
		logic                ok;
		logic [ENTRY_W-1:0]  given_entry;
		status_t             status;
		logic [COUNT_W-1:0]  released_count;
	} res_t;

	// engine to output register
	typedef struct packed {
		logic fin;
		res_t res;
	} done_t;

	// per-entry flags
	typedef struct packed {
		logic alloc;
		logic pend;
	} flag_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_REL,
		S_CMT_RD,
		S_CMT_WR,
		S_RESP
	} state_t;

endpackage

FILE: rtl/mpfl_req_if.sv
// ----------------------------------------------------------------------------
// mpfl_req_if
// Request channel: valid/ready handshake with op, pool and entry.
// ----------------------------------------------------------------------------
interface mpfl_req_if;
	import mpfl_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [POOL_W-1:0]   pool;
	logic [ENTRY_W-1:0]  entry;

	modport source (output valid, output op, output pool, output entry, input ready);
	modport sink   (input valid, input op, input pool, input entry, output ready);
endinterface

FILE: rtl/mpfl_res_if.sv
// ----------------------------------------------------------------------------
// mpfl_res_if
// Result channel: valid/ready handshake with the four result fields.
// ----------------------------------------------------------------------------
interface mpfl_res_if;
	import mpfl_pkg::*;

	logic                valid;
	logic                ready;
	logic                ok;
	logic [ENTRY_W-1:0]  given_entry;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  released_count;

	modport source (output valid, output ok, output given_entry, output status,
		output released_count, input ready);
	modport sink   (input valid, input ok, input given_entry, input status,
		input released_count, output ready);
endinterface

FILE: rtl/mpfl_engine.sv
// ----------------------------------------------------------------------------
// mpfl_engine
// Sequencer over the free stack, pending list and flag memories, with the
// per-pool free and pending counters and the reset clearing pass.
// ----------------------------------------------------------------------------
module mpfl_engine (
	input  logic            clk,
	input  logic            arst_n,
	mpfl_req_if.sink        req,
	input  logic            take,
	output mpfl_pkg::done_t done
);
	import mpfl_pkg::*;

	// flat slot address of a pool and an index within it
	function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p,
		input logic [EW-1:0] k);
		return AW'(32'(p) * POOL_DEPTH + 32'(k));
	endfunction

	function automatic res_t make_res(input logic ok, input logic [ENTRY_W-1:0] given,
		input status_t st, input logic [COUNT_W-1:0] cnt);
		res_t r;
		r.ok             = ok;
		r.given_entry    = given;
		r.status         = st;
		r.released_count = cnt;
		return r;
	endfunction

	// control and request registers
	state_t          state_q, state_d;
	logic [PW-1:0]   p_q, p_d;
	logic [CW-1:0]   k_q, k_d;
	logic [TW-1:0]   total_q, total_d;
	logic [PW-1:0]   pool_q, pool_d;
	logic [EW-1:0]   entry_q, entry_d;
	res_t            stage_q, stage_d;

	// per-pool counters
	logic [CW-1:0]   fc_q [NUM_POOLS];
	logic [CW-1:0]   pc_q [NUM_POOLS];

	// memories
	logic [EW-1:0]   fs_mem [SLOTS];
	logic [EW-1:0]   pl_mem [SLOTS];
	flag_t           fl_mem [SLOTS];
	logic [EW-1:0]   fs_rdata_q;
	logic [EW-1:0]   pl_rdata_q;
	flag_t           fl_rdata_q;

	// memory and counter access controls
	logic            fs_we, fs_re, pl_we, pl_re, fl_we, fl_re;
	logic [AW-1:0]   fs_wa, fs_ra, pl_wa, pl_ra, fl_wa, fl_ra;
	logic [EW-1:0]   fs_wd, pl_wd;
	flag_t           fl_wd;
	logic            fc_we, pc_we;
	logic [CW-1:0]   fc_wd, pc_wd;

	logic            in_pool_ok, in_entry_ok;
	logic [PW-1:0]   cur_pool;
	logic [CW-1:0]   fc_cur, pc_cur, fc_m1;
	logic            fin;
	res_t            fin_res;

	assign in_pool_ok  = 32'(req.pool) < NUM_POOLS;
	assign in_entry_ok = 32'(req.entry) < POOL_DEPTH;

	// pool whose counters are looked at this cycle
	always_comb begin
		unique case (state_q)
			S_IDLE:          cur_pool = in_pool_ok ? PW'(req.pool) : '0;
			S_ALLOC, S_REL:  cur_pool = pool_q;
			default:         cur_pool = p_q;
		endcase
	end

	assign fc_cur = fc_q[cur_pool];
	assign pc_cur = pc_q[cur_pool];
	assign fc_m1  = fc_cur - 1'b1;

	assign req.ready = (state_q == S_IDLE);

	// next state and outputs
	always_comb begin
		state_d = state_q;
		p_d     = p_q;
		k_d     = k_q;
		total_d = total_q;
		pool_d  = pool_q;
		entry_d = entry_q;
		stage_d = stage_q;
		fs_we = 1'b0; fs_wa = '0; fs_wd = '0; fs_re = 1'b0; fs_ra = '0;
		pl_we = 1'b0; pl_wa = '0; pl_wd = '0; pl_re = 1'b0; pl_ra = '0;
		fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
		fc_we = 1'b0; fc_wd = '0;
		pc_we = 1'b0; pc_wd = '0;
		fin     = 1'b0;
		fin_res = make_res(1'b0, '0, STAT_SUCCESS, '0);

		unique case (state_q)
			// write initial stack contents and clear flags, one slot a cycle
			S_CLEAR: begin
				fs_we = 1'b1;
				fs_wa = slot_addr(p_q, k_q[EW-1:0]);
				fs_wd = k_q[EW-1:0];
				fl_we = 1'b1;
				fl_wa = slot_addr(p_q, k_q[EW-1:0]);
				fl_wd = '{alloc: 1'b0, pend: 1'b0};
				if (32'(k_q) == POOL_DEPTH - 1) begin
					k_d = '0;
					if (32'(p_q) == NUM_POOLS - 1) begin
						p_d     = '0;
						state_d = S_IDLE;
					end else begin
						p_d = p_q + 1'b1;
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end

			// decode a new request and start its memory read
			S_IDLE: begin
				if (req.valid) begin
					pool_d  = cur_pool;
					entry_d = EW'(req.entry);
					case (req.op)
						OP_ALLOC: begin
							if (!in_pool_ok || fc_cur == '0) begin
								fin     = 1'b1;
								fin_res = make_res(1'b0, '0, STAT_EMPTY, '0);
							end else begin
								fs_re   = 1'b1;
								fs_ra   = slot_addr(cur_pool, fc_m1[EW-1:0]);
								fc_we   = 1'b1;
								fc_wd   = fc_m1;
								state_d = S_ALLOC;
							end
						end
						OP_RELEASE: begin
							if (!in_pool_ok || !in_entry_ok) begin
								fin     = 1'b1;
								fin_res = make_res(1'b0, '0, STAT_NOT_ALLOC, '0);
							end else begin
								fl_re   = 1'b1;
								fl_ra   = slot_addr(cur_pool, EW'(req.entry));
								state_d = S_REL;
							end
						end
						OP_COMMIT: begin
							p_d     = '0;
							k_d     = '0;
							total_d = '0;
							state_d = S_CMT_RD;
						end
						default: begin
							fin     = 1'b1;
							fin_res = make_res(1'b0, '0, STAT_SUCCESS, '0);
						end
					endcase
				end
			end

			// popped index arrives: mark it allocated
			S_ALLOC: begin
				fl_we   = 1'b1;
				fl_wa   = slot_addr(pool_q, fs_rdata_q);
				fl_wd   = '{alloc: 1'b1, pend: 1'b0};
				fin     = 1'b1;
				fin_res = make_res(1'b1, ENTRY_W'(fs_rdata_q), STAT_SUCCESS, '0);
			end

			// flags arrive: check and queue the release
			S_REL: begin
				fin = 1'b1;
				if (!fl_rdata_q.alloc) begin
					fin_res = make_res(1'b0, '0, STAT_NOT_ALLOC, '0);
				end else if (fl_rdata_q.pend || 32'(pc_cur) >= POOL_DEPTH) begin
					fin_res = make_res(1'b0, '0, STAT_PENDING, '0);
				end else begin
					fl_we   = 1'b1;
					fl_wa   = slot_addr(pool_q, entry_q);
					fl_wd   = '{alloc: 1'b1, pend: 1'b1};
					pl_we   = 1'b1;
					pl_wa   = slot_addr(pool_q, pc_cur[EW-1:0]);
					pl_wd   = entry_q;
					pc_we   = 1'b1;
					pc_wd   = pc_cur + 1'b1;
					fin_res = make_res(1'b1, '0, STAT_SUCCESS, '0);
				end
			end

			// commit walk: fetch the next pending entry or move to the next pool
			S_CMT_RD: begin
				if (k_q == pc_cur) begin
					pc_we = 1'b1;
					pc_wd = '0;
					k_d   = '0;
					if (32'(p_q) == NUM_POOLS - 1) begin
						fin     = 1'b1;
						fin_res = make_res(1'b1, '0, STAT_SUCCESS, COUNT_W'(total_q));
					end else begin
						p_d = p_q + 1'b1;
					end
				end else begin
					pl_re   = 1'b1;
					pl_ra   = slot_addr(p_q, k_q[EW-1:0]);
					k_d     = k_q + 1'b1;
					state_d = S_CMT_WR;
				end
			end

			// commit walk: push the fetched entry and clear its flags
			S_CMT_WR: begin
				if (32'(fc_cur) < POOL_DEPTH) begin
					fl_we   = 1'b1;
					fl_wa   = slot_addr(p_q, pl_rdata_q);
					fl_wd   = '{alloc: 1'b0, pend: 1'b0};
					fs_we   = 1'b1;
					fs_wa   = slot_addr(p_q, fc_cur[EW-1:0]);
					fs_wd   = pl_rdata_q;
					fc_we   = 1'b1;
					fc_wd   = fc_cur + 1'b1;
					total_d = total_q + 1'b1;
				end
				state_d = S_CMT_RD;
			end

			// result waits for the output register
			S_RESP: begin
				fin     = 1'b1;
				fin_res = stage_q;
			end

			default: state_d = S_IDLE;
		endcase

		// hand over the result, or hold it while the output register is full
		if (fin) begin
			stage_d = fin_res;
			state_d = take ? S_IDLE : S_RESP;
		end
	end

	assign done.fin = fin;
	assign done.res = fin_res;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			p_q     <= '0;
			k_q     <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			p_q     <= p_d;
			k_q     <= k_d;
			total_q <= total_d;
		end
	end

	// request and staged result payload
	always_ff @(posedge clk) begin
		pool_q  <= pool_d;
		entry_q <= entry_d;
		stage_q <= stage_d;
	end

	// per-pool counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POOLS; i++) begin
				fc_q[i] <= CW'(POOL_DEPTH);
				pc_q[i] <= '0;
			end
		end else begin
			if (fc_we) fc_q[cur_pool] <= fc_wd;
			if (pc_we) pc_q[cur_pool] <= pc_wd;
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[fs_wa] <= fs_wd;
		if (fs_re) fs_rdata_q <= fs_mem[fs_ra];
	end

	// pending list memory
	always_ff @(posedge clk) begin
		if (pl_we) pl_mem[pl_wa] <= pl_wd;
		if (pl_re) pl_rdata_q <= pl_mem[pl_ra];
	end

	// entry flag memory
	always_ff @(posedge clk) begin
		if (fl_we) fl_mem[fl_wa] <= fl_wd;
		if (fl_re) fl_rdata_q <= fl_mem[fl_ra];
	end

	// counters stay within the pool depth
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fc_cur) <= POOL_DEPTH) && (32'(pc_cur) <= POOL_DEPTH))
		else $error("pool counter beyond pool depth");

	// each read-data state comes in the cycle after its memory read
	a_alloc_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC) |-> $past(fs_re))
		else $error("allocate without free stack read");

	a_rel_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REL) |-> $past(fl_re))
		else $error("release check without flag read");

	a_cmt_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMT_WR) |-> $past(pl_re))
		else $error("commit push without pending list read");

	// a result is held back only when the output register was full
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> ($past(fin) && !$past(take)))
		else $error("result held although output register was free");

endmodule

FILE: rtl/multi_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// multi_pool_free_list_allocator
// Several fixed pools of entry indices with LIFO free stacks, deferred
// releases and a commit that returns every pending entry.
//
//  channel  direction  handshake      payload
//  req      in         valid/ready    op, pool, entry
//  res      out        valid/ready    ok, given_entry, status, released_count
//
// Allocate and release start a memory read when the request is taken and
// finish in S_ALLOC or S_REL; rejected requests and op 3 finish in S_IDLE.
// A commit runs from the request through one pool step per pool and a read
// then a push per pending entry.
// After reset a clearing pass over NUM_POOLS x POOL_DEPTH slots (448) fills
// the free stacks and clears the flags; req.ready stays low during it.
// A result may wait in the output register while the next request is taken;
// a further result is held inside the engine until the register drains.
// ----------------------------------------------------------------------------
module multi_pool_free_list_allocator (
	input  logic       clk,
	input  logic       arst_n,
	mpfl_req_if.sink   req,
	mpfl_res_if.source res
);
	import mpfl_pkg::*;

	done_t done;
	logic  take;
	logic  out_valid_q;
	res_t  out_q;

	mpfl_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.take   (take),
		.done   (done)
	);

	// output register is free when empty or being drained
	assign take = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done.fin && take) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done.fin && take) out_q <= done.res;
	end

	assign res.valid          = out_valid_q;
	assign res.ok             = out_q.ok;
	assign res.given_entry    = out_q.given_entry;
	assign res.status         = out_q.status;
	assign res.released_count = out_q.released_count;

endmodule
